>>> rtl/core/bvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvd_pkg
// Shared types, codes and helpers for the biased varint decoder.
// ----------------------------------------------------------------------------
package bvd_pkg;

  // Byte layout
  localparam int unsigned PAYLOAD_W = 7;
  localparam logic [7:0]  PAYLOAD_MASK = 8'h7F;

  // Group index: 1..9 are live shifts (7..63), GRP_SAT means shift >= 64
  localparam int unsigned GRP_W   = 4;
  localparam logic [GRP_W-1:0] GRP_FIRST = 4'd1;
  localparam logic [GRP_W-1:0] GRP_TOP   = 4'd9;
  localparam logic [GRP_W-1:0] GRP_SAT   = 4'd10;

  // decode_mode register
  localparam logic [1:0] MODE_U64    = 2'd0;
  localparam logic [1:0] MODE_U32    = 2'd1;
  localparam logic [1:0] MODE_ZIGZAG = 2'd2;

  // error_code values
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_OVER64    = 2'd2;
  localparam logic [1:0] ERR_OVER32    = 2'd3;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } bvd_item_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [1:0]  error_code;
  } bvd_result_t;

  // Shift amount for a group: 7 * grp
  function automatic logic [6:0] grp_shift(input logic [GRP_W-1:0] grp);
    logic [6:0] g;
    g = 7'(grp);
    return (g << 3) - g;
  endfunction

endpackage : bvd_pkg
`default_nettype wire

>>> rtl/core/biased_varint_decoder_unit.sv
`default_nettype none
// A final byte moves from the input register through decode to the result register.
// One byte per cycle unless out_tready stalls; single decode stage (64-bit shift-add).
// A stalled output holds one result while one more byte waits in the input register.
// Reset (rst_n low, synchronous) empties both registers, clears the number state
// and sets decode_mode to unsigned 64-bit.
// ----------------------------------------------------------------------------
// biased_varint_decoder_unit
// Stream decoder for biased little-endian varints with three output modes.
// ----------------------------------------------------------------------------
module biased_varint_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] code_byte
  input  wire logic        in_tlast,   // stream_end
  // decoded values
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value_bits
  output logic [1:0]       out_tuser,  // [1:0] error_code
  // decode_mode register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data
);
  import bvd_pkg::*;

  logic [1:0]  decode_mode_r;
  bvd_item_t   in_item, s1_item;
  logic        s1_valid, take, out_free, res_valid;
  bvd_result_t res, out_res;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= MODE_U64;
    end else if (cfg_valid) begin
      decode_mode_r <= cfg_data;
    end
  end

  assign in_item.code_byte  = in_tdata;
  assign in_item.stream_end = in_tlast;

  // a held byte is decoded when the result register can take its outcome
  assign take = s1_valid && out_free;

  bvd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  bvd_decode u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (take),
    .item        (s1_item),
    .decode_mode (decode_mode_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  bvd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.value_bits;
  assign out_tuser = out_res.error_code;

`ifndef SYNTHESIS
  // any error result carries a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ERR_OK)) |-> (out_tdata == 64'd0))
    else $error("error result with non-zero value");

  // input only backs up when a byte is held and the output is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // range error only appears under the 32-bit mode
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.error_code == ERR_OVER32) |-> (decode_mode_r == MODE_U32))
    else $error("32-bit range error outside 32-bit mode");
`endif

endmodule : biased_varint_decoder_unit
`default_nettype wire

>>> rtl/core/bvd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvd_in_stage
// Input register: holds one stream byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module bvd_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire bvd_pkg::bvd_item_t in_item,
  input  wire logic               take,      // decode stage consumes the held byte
  output logic                    item_valid,
  output bvd_pkg::bvd_item_t      item
);
  import bvd_pkg::*;

  logic      valid_r, valid_nxt;
  bvd_item_t item_r;
  logic      load;

  // free when empty or when the held request leaves this cycle
  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule : bvd_in_stage
`default_nettype wire

>>> rtl/core/bvd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvd_decode
// Number state and per-byte decode: accumulate, detect overflow, format.
// ----------------------------------------------------------------------------
module bvd_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,       // one byte processed this cycle
  input  wire bvd_pkg::bvd_item_t item,
  input  wire logic [1:0]         decode_mode,
  output logic                    res_valid,
  output bvd_pkg::bvd_result_t    res
);
  import bvd_pkg::*;

  logic [63:0]      acc_r, acc_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic             in_num_r, in_num_nxt;
  logic             ovf_r, ovf_nxt;

  logic [7:0]       payload;
  logic [63:0]      shifted;
  logic [64:0]      sum;
  logic [63:0]      acc_new;
  logic             ovf_new;
  logic [GRP_W-1:0] grp_new;
  bvd_result_t      fin;

  assign payload = {1'b0, item.code_byte[6:0]} + 8'd1;
  assign shifted = {56'd0, payload} << grp_shift(grp_r);
  assign sum     = {1'b0, acc_r} + {1'b0, shifted};

  // accumulate this byte into the number
  always_comb begin
    acc_new = acc_r;
    ovf_new = ovf_r;
    grp_new = grp_r;
    if (!in_num_r) begin
      acc_new = {57'd0, item.code_byte[PAYLOAD_W-1:0]};
      ovf_new = 1'b0;
      grp_new = GRP_FIRST;
    end else if (grp_r >= GRP_SAT) begin
      ovf_new = 1'b1;
    end else begin
      if ((grp_r == GRP_TOP) && (payload[7:1] != 7'd0)) begin
        ovf_new = 1'b1;
      end else begin
        acc_new = sum[63:0];
        ovf_new = ovf_r || sum[64];
      end
      grp_new = grp_r + GRP_W'(1);
    end
  end

  // present the finished number
  always_comb begin
    fin.value_bits = acc_new;
    fin.error_code = ERR_OK;
    if (ovf_new) begin
      fin.value_bits = 64'd0;
      fin.error_code = ERR_OVER64;
    end else begin
      unique case (decode_mode)
        MODE_U32: begin
          if (acc_new[63:32] != 32'd0) begin
            fin.value_bits = 64'd0;
            fin.error_code = ERR_OVER32;
          end
        end
        MODE_ZIGZAG: begin
          fin.value_bits = {1'b0, acc_new[63:1]} ^ {64{acc_new[0]}};
        end
        default: begin
          fin.value_bits = acc_new;
        end
      endcase
    end
  end

  // end of number, truncation, or carry on
  always_comb begin
    acc_nxt    = acc_r;
    grp_nxt    = grp_r;
    in_num_nxt = in_num_r;
    ovf_nxt    = ovf_r;
    res_valid  = 1'b0;
    res        = fin;
    if (fire) begin
      priority if (!item.code_byte[7]) begin
        res_valid  = 1'b1;
        acc_nxt    = 64'd0;
        grp_nxt    = '0;
        in_num_nxt = 1'b0;
        ovf_nxt    = 1'b0;
      end else if (item.stream_end) begin
        res_valid      = 1'b1;
        res.value_bits = 64'd0;
        res.error_code = ERR_TRUNCATED;
        acc_nxt        = 64'd0;
        grp_nxt        = '0;
        in_num_nxt     = 1'b0;
        ovf_nxt        = 1'b0;
      end else begin
        acc_nxt    = acc_new;
        grp_nxt    = grp_new;
        in_num_nxt = 1'b1;
        ovf_nxt    = ovf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 64'd0;
      grp_r    <= '0;
      in_num_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      grp_r    <= grp_nxt;
      in_num_r <= in_num_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule : bvd_decode
`default_nettype wire

>>> rtl/core/bvd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvd_out_stage
// Result register between the decode stage and the output stream.
// ----------------------------------------------------------------------------
module bvd_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 res_valid,
  input  wire bvd_pkg::bvd_result_t res,
  output logic                      out_free,  // may load a result this cycle
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output bvd_pkg::bvd_result_t      out_res
);
  import bvd_pkg::*;

  logic        valid_r, valid_nxt;
  bvd_result_t res_r;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule : bvd_out_stage
`default_nettype wire
